>>> src/rcc_pkg.sv
// Shared types, constants and a saturating adder of the capped cylinder intersector.
package rcc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int WS        = 64 - FRAC_BITS;
    localparam int MAGW      = 62 - FRAC_BITS;
    localparam int DISTW     = WORD_BITS - 1;
    localparam int EPSW      = 16;
    localparam int QDEPTH    = 2;
    localparam int QAW       = $clog2(QDEPTH);

    typedef logic signed [WS-1:0] t_w;

    localparam t_w WMAX  = {{(WS-MAGW){1'b0}}, {MAGW{1'b1}}};
    localparam t_w ONE_Q = {{(WS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [1:0] SURF_BOTTOM = 2'd0;
    localparam logic [1:0] SURF_TOP    = 2'd1;
    localparam logic [1:0] SURF_SIDE   = 2'd2;

    localparam logic            CFG_OPEN_ENDS = 1'b0;
    localparam logic            CFG_EPSILON   = 1'b1;
    localparam logic [EPSW-1:0] EPS_RESET     = 16'd66;

    typedef struct packed {
        t_w              ox;
        t_w              oy;
        t_w              oz;
        t_w              dx;
        t_w              dy;
        t_w              dz;
        t_w              lim;
        t_w              factor;
        logic            unlimited;
        logic            cap_test;
        logic [EPSW-1:0] eps;
    } t_ray;

    function automatic t_w addw(input t_w a, input t_w b);
        logic signed [WS:0] s;
        logic signed [WS:0] mx;
        s  = {a[WS-1], a} + {b[WS-1], b};
        mx = {1'b0, WMAX};
        if (s > mx) begin
            return WMAX;
        end else if (s < -mx) begin
            return -WMAX;
        end
        return s[WS-1:0];
    endfunction

endpackage

>>> src/rcc_front.sv
// Front end: configuration registers, ray classification and the ray queue.
module rcc_front import rcc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WORD_BITS-1:0] i_origin_x,
    input  logic [WORD_BITS-1:0] i_origin_y,
    input  logic [WORD_BITS-1:0] i_origin_z,
    input  logic [WORD_BITS-1:0] i_dir_x,
    input  logic [WORD_BITS-1:0] i_dir_y,
    input  logic [WORD_BITS-1:0] i_dir_z,
    input  logic [DISTW-1:0] i_ray_limit,
    input  logic [DISTW-1:0] i_scale_factor,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [EPSW-1:0]  i_cfg_data,
    output logic             o_q_valid,
    output t_ray             o_q_head,
    input  logic             i_q_pop
);

    logic            r_open_ends;
    logic [EPSW-1:0] r_epsilon;
    t_ray            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp;
    logic [QAW-1:0]  r_rp;
    logic [QAW:0]    r_cnt;
    t_ray            ray_n;
    logic [WORD_BITS-1:0] mag_dy;
    logic [DISTW-1:0]     fac;
    logic                 push;

    always_comb begin
        ray_n.ox  = {{(WS-WORD_BITS){i_origin_x[WORD_BITS-1]}}, i_origin_x};
        ray_n.oy  = {{(WS-WORD_BITS){i_origin_y[WORD_BITS-1]}}, i_origin_y};
        ray_n.oz  = {{(WS-WORD_BITS){i_origin_z[WORD_BITS-1]}}, i_origin_z};
        ray_n.dx  = {{(WS-WORD_BITS){i_dir_x[WORD_BITS-1]}}, i_dir_x};
        ray_n.dy  = {{(WS-WORD_BITS){i_dir_y[WORD_BITS-1]}}, i_dir_y};
        ray_n.dz  = {{(WS-WORD_BITS){i_dir_z[WORD_BITS-1]}}, i_dir_z};
        mag_dy    = i_dir_y[WORD_BITS-1] ? (~i_dir_y + 1'b1) : i_dir_y;
        fac       = (i_scale_factor == '0) ? DISTW'(1) : i_scale_factor;
        ray_n.lim       = {{(WS-DISTW){1'b0}}, i_ray_limit};
        ray_n.factor    = {{(WS-DISTW){1'b0}}, fac};
        ray_n.unlimited = &i_ray_limit;
        ray_n.cap_test  = !(mag_dy < WORD_BITS'(r_epsilon)) && (i_dir_y != '0) && !r_open_ends;
        ray_n.eps       = r_epsilon;
    end

    assign o_ready   = (r_cnt != (QAW+1)'(QDEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_ends <= 1'b0;
            r_epsilon   <= EPS_RESET;
            r_wp        <= '0;
            r_rp        <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OPEN_ENDS: r_open_ends <= i_cfg_data[0];
                    CFG_EPSILON:   r_epsilon   <= i_cfg_data;
                    default:       r_epsilon   <= r_epsilon;
                endcase
            end
            if (push) begin
                r_mem[r_wp] <= ray_n;
                r_wp        <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(i_q_pop);
        end
    end

endmodule

>>> src/rcc_mul.sv
// Saturating fixed point multiplier built from four narrow partial products.
module rcc_mul import rcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_w   i_a,
    input  t_w   i_b,
    output logic o_done,
    output t_w   o_res
);

    localparam int H    = (MAGW + 1) / 2;
    localparam int ACCW = 4 * H;
    localparam logic [2:0] CNT_DONE = 3'd5;

    logic [2*H-1:0]  r_ma;
    logic [2*H-1:0]  r_mb;
    logic            r_neg;
    logic            r_busy;
    logic [2:0]      r_cnt;
    logic [2*H-1:0]  r_pp;
    logic [ACCW-1:0] r_acc;
    logic [H-1:0]    mx;
    logic [H-1:0]    my;
    logic [ACCW-1:0] add_n;
    logic [ACCW-1:0] prod;
    logic [MAGW-1:0] mag;
    t_w              ua;
    t_w              ub;

    always_comb begin
        ua = i_a[WS-1] ? -i_a : i_a;
        ub = i_b[WS-1] ? -i_b : i_b;
        case (r_cnt)
            3'd0:    begin mx = r_ma[H-1:0];   my = r_mb[H-1:0];   end
            3'd1:    begin mx = r_ma[H-1:0];   my = r_mb[2*H-1:H]; end
            3'd2:    begin mx = r_ma[2*H-1:H]; my = r_mb[H-1:0];   end
            default: begin mx = r_ma[2*H-1:H]; my = r_mb[2*H-1:H]; end
        endcase
        case (r_cnt)
            3'd1:    add_n = ACCW'(r_pp);
            3'd2:    add_n = ACCW'(r_pp) << H;
            3'd3:    add_n = ACCW'(r_pp) << H;
            3'd4:    add_n = ACCW'(r_pp) << (2 * H);
            default: add_n = '0;
        endcase
        prod  = r_acc >> FRAC_BITS;
        mag   = (|prod[ACCW-1:MAGW]) ? {MAGW{1'b1}} : prod[MAGW-1:0];
        o_res = r_neg ? -t_w'({{(WS-MAGW){1'b0}}, mag}) : t_w'({{(WS-MAGW){1'b0}}, mag});
    end

    assign o_done = r_busy && (r_cnt == CNT_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_ma   <= ua[2*H-1:0];
            r_mb   <= ub[2*H-1:0];
            r_neg  <= i_a[WS-1] ^ i_b[WS-1];
            r_acc  <= '0;
        end else if (r_busy) begin
            r_pp  <= (2*H)'(mx) * (2*H)'(my);
            r_acc <= r_acc + add_n;
            if (r_cnt == CNT_DONE) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

>>> src/rcc_divsqrt.sv
// Shared iterative unit: saturating fixed point divide or floored square root, one bit a cycle.
module rcc_divsqrt import rcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_sqrt,
    input  t_w   i_a,
    input  t_w   i_b,
    output logic o_done,
    output t_w   o_res
);

    localparam int NB    = MAGW + FRAC_BITS;
    localparam int SQ_IT = (NB - 1) / 2 + 1;
    localparam int CW    = $clog2(NB + 1);
    localparam logic [NB:0] BIT_START = (NB+1)'(1) << (2 * ((NB - 1) / 2));

    logic            r_busy;
    logic            r_mode;
    logic [CW-1:0]   r_cnt;
    logic            r_neg;
    logic [NB-1:0]   r_num;
    logic [MAGW:0]   r_rem;
    logic [MAGW-1:0] r_den;
    logic [NB-1:0]   r_q;
    logic [NB:0]     r_x;
    logic [NB:0]     r_root;
    logic [NB:0]     r_bit;
    t_w              ua;
    t_w              ub;
    logic [MAGW:0]   rem_sh;
    logic [NB:0]     trial;
    logic [MAGW-1:0] qmag;

    always_comb begin
        ua     = i_a[WS-1] ? -i_a : i_a;
        ub     = i_b[WS-1] ? -i_b : i_b;
        rem_sh = {r_rem[MAGW-1:0], r_num[NB-1]};
        trial  = r_root + r_bit;
        qmag   = (|r_q[NB-1:MAGW]) ? {MAGW{1'b1}} : r_q[MAGW-1:0];
        if (r_mode) begin
            o_res = {{(WS-MAGW){1'b0}}, r_root[MAGW-1:0]};
        end else if (r_neg) begin
            o_res = -t_w'({{(WS-MAGW){1'b0}}, qmag});
        end else begin
            o_res = {{(WS-MAGW){1'b0}}, qmag};
        end
    end

    assign o_done = r_busy && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_mode <= i_sqrt;
            r_cnt  <= i_sqrt ? CW'(SQ_IT) : CW'(NB);
            r_neg  <= i_a[WS-1] ^ i_b[WS-1];
            r_num  <= {ua[MAGW-1:0], {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_den  <= ub[MAGW-1:0];
            r_q    <= '0;
            r_x    <= {1'b0, ua[MAGW-1:0], {FRAC_BITS{1'b0}}};
            r_root <= '0;
            r_bit  <= BIT_START;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
                if (r_mode) begin
                    if (r_x >= trial) begin
                        r_x    <= r_x - trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    r_num <= r_num << 1;
                    if (rem_sh >= {1'b0, r_den}) begin
                        r_rem <= rem_sh - {1'b0, r_den};
                        r_q   <= {r_q[NB-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_q   <= {r_q[NB-2:0], 1'b0};
                    end
                end
            end
        end
    end

endmodule

>>> src/rcc_back.sv
// Back end: sequencer that runs cap and side tests on the shared units and delivers hit beats, or a miss beat.
module rcc_back import rcc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_ray             i_ray,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_hit_valid,
    output logic [1:0]       o_surface,
    output logic [DISTW-1:0] o_distance,
    output logic             o_last
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_ISSUE = 4'b0010,
        PH_WAIT  = 4'b0100,
        PH_POST  = 4'b1000
    } t_phase;

    typedef logic [4:0] t_step;
    typedef logic [1:0] t_kind;

    localparam t_step S_LIM   = 5'd0;
    localparam t_step S_CDIV  = 5'd1;
    localparam t_step S_CPX   = 5'd2;
    localparam t_step S_CPZ   = 5'd3;
    localparam t_step S_CX2   = 5'd4;
    localparam t_step S_CZ2   = 5'd5;
    localparam t_step S_CEMIT = 5'd6;
    localparam t_step S_A1    = 5'd7;
    localparam t_step S_A2    = 5'd8;
    localparam t_step S_H1    = 5'd9;
    localparam t_step S_H2    = 5'd10;
    localparam t_step S_C1    = 5'd11;
    localparam t_step S_C2    = 5'd12;
    localparam t_step S_E1    = 5'd13;
    localparam t_step S_E2    = 5'd14;
    localparam t_step S_SQ    = 5'd15;
    localparam t_step S_SDIV  = 5'd16;
    localparam t_step S_SPY   = 5'd17;
    localparam t_step S_SEMIT = 5'd18;
    localparam t_step S_DONE  = 5'd19;

    localparam t_kind K_NONE = 2'd0;
    localparam t_kind K_MUL  = 2'd1;
    localparam t_kind K_DIV  = 2'd2;
    localparam t_kind K_SQRT = 2'd3;

    localparam t_w DIST_MAX_W = {{(WS-DISTW){1'b0}}, {DISTW{1'b1}}};

    t_phase r_phase;
    t_step  r_step;
    logic   r_side;
    logic [1:0] r_caps;
    t_w     r_res;
    t_w     r_llim;
    t_w     r_s;
    t_w     r_px;
    t_w     r_pz;
    t_w     r_t;
    t_w     r_a;
    t_w     r_h;
    t_w     r_c;
    t_w     r_e;
    t_w     r_sq;
    logic             r_pend_v;
    logic [1:0]       r_pend_surf;
    logic [DISTW-1:0] r_pend_dist;
    logic             r_out_v;
    logic             r_out_hit;
    logic [1:0]       r_out_surf;
    logic [DISTW-1:0] r_out_dist;
    logic             r_out_last;

    t_kind kind;
    t_w    opa;
    t_w    opb;
    logic  mul_start;
    logic  ds_start;
    logic  mul_done;
    logic  ds_done;
    t_w    mul_res;
    t_w    ds_res;
    t_w    eps_w;
    t_w    r2_n;
    t_w    e_n;
    t_w    py_n;
    logic signed [WS+1:0] e4;
    logic signed [WS+1:0] eps4;
    logic             out_free;
    logic             emit_en;
    logic [1:0]       emit_surf;
    logic [DISTW-1:0] emit_dist;
    logic             post_ok;
    logic             out_load;

    always_comb begin
        kind = K_MUL;
        opa  = r_s;
        opb  = r_s;
        case (r_step)
            S_LIM: begin
                kind = i_ray.unlimited ? K_NONE : K_DIV;
                opa  = i_ray.lim;
                opb  = i_ray.factor;
            end
            S_CDIV: begin
                kind = K_DIV;
                opa  = r_side ? addw(ONE_Q, -i_ray.oy) : addw(-ONE_Q, -i_ray.oy);
                opb  = i_ray.dy;
            end
            S_CPX:   begin opa = i_ray.dx;     opb = r_s;      end
            S_CPZ:   begin opa = i_ray.dz;     opb = r_s;      end
            S_CX2:   begin opa = r_px;         opb = r_px;     end
            S_CZ2:   begin opa = r_pz;         opb = r_pz;     end
            S_CEMIT: begin opa = i_ray.factor; opb = r_s;      end
            S_A1:    begin opa = i_ray.dx;     opb = i_ray.dx; end
            S_A2:    begin opa = i_ray.dz;     opb = i_ray.dz; end
            S_H1:    begin opa = i_ray.ox;     opb = i_ray.dx; end
            S_H2:    begin opa = i_ray.oz;     opb = i_ray.dz; end
            S_C1:    begin opa = i_ray.ox;     opb = i_ray.ox; end
            S_C2:    begin opa = i_ray.oz;     opb = i_ray.oz; end
            S_E1:    begin opa = r_h;          opb = r_h;      end
            S_E2:    begin opa = r_a;          opb = r_c;      end
            S_SQ: begin
                kind = K_SQRT;
                opa  = r_e;
                opb  = r_e;
            end
            S_SDIV: begin
                kind = K_DIV;
                opa  = addw(-r_h, r_side ? -r_sq : r_sq);
                opb  = r_a;
            end
            S_SPY:   begin opa = i_ray.dy;     opb = r_s;      end
            S_SEMIT: begin opa = i_ray.factor; opb = r_s;      end
            S_DONE:  kind = K_NONE;
            default: kind = K_NONE;
        endcase
    end

    assign mul_start = (r_phase == PH_ISSUE) && (kind == K_MUL);
    assign ds_start  = (r_phase == PH_ISSUE) && ((kind == K_DIV) || (kind == K_SQRT));

    rcc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (opa),
        .i_b     (opb),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    rcc_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ds_start),
        .i_sqrt  (kind == K_SQRT),
        .i_a     (opa),
        .i_b     (opb),
        .o_done  (ds_done),
        .o_res   (ds_res)
    );

    always_comb begin
        eps_w     = {{(WS-EPSW){1'b0}}, i_ray.eps};
        r2_n      = addw(r_t, r_res);
        e_n       = addw(r_t, -r_res);
        py_n      = addw(i_ray.oy, r_res);
        e4        = {e_n, 2'b00};
        eps4      = {{(WS+2-EPSW){1'b0}}, i_ray.eps};
        out_free  = !r_out_v || i_ready;
        emit_en   = (r_step == S_CEMIT) || (r_step == S_SEMIT);
        emit_surf = (r_step == S_SEMIT) ? SURF_SIDE : (r_side ? SURF_TOP : SURF_BOTTOM);
        if (r_res[WS-1]) begin
            emit_dist = '0;
        end else if (r_res > DIST_MAX_W) begin
            emit_dist = {DISTW{1'b1}};
        end else begin
            emit_dist = r_res[DISTW-1:0];
        end
        if (r_step == S_DONE) begin
            post_ok = out_free;
        end else if (emit_en) begin
            post_ok = !r_pend_v || out_free;
        end else begin
            post_ok = 1'b1;
        end
        out_load = (r_phase == PH_POST) && post_ok &&
                   ((emit_en && r_pend_v) || (r_step == S_DONE));
    end

    assign o_q_pop     = (r_phase == PH_POST) && (r_step == S_DONE) && out_free;
    assign o_valid     = r_out_v;
    assign o_hit_valid = r_out_hit;
    assign o_surface   = r_out_surf;
    assign o_distance  = r_out_dist;
    assign o_last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_step   <= S_LIM;
            r_side   <= 1'b0;
            r_caps   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
            case (r_phase)
                PH_IDLE: begin
                    if (i_q_valid) begin
                        r_step  <= S_LIM;
                        r_phase <= PH_ISSUE;
                    end
                end
                PH_ISSUE: begin
                    r_res   <= WMAX;
                    r_phase <= (kind == K_NONE) ? PH_POST : PH_WAIT;
                end
                PH_WAIT: begin
                    if (mul_done) begin
                        r_res   <= mul_res;
                        r_phase <= PH_POST;
                    end else if (ds_done) begin
                        r_res   <= ds_res;
                        r_phase <= PH_POST;
                    end
                end
                PH_POST: begin
                    if (post_ok) begin
                        r_phase <= PH_ISSUE;
                        if (emit_en) begin
                            if (r_pend_v) begin
                                r_out_hit  <= 1'b1;
                                r_out_surf <= r_pend_surf;
                                r_out_dist <= r_pend_dist;
                                r_out_last <= 1'b0;
                            end
                            r_pend_v    <= 1'b1;
                            r_pend_surf <= emit_surf;
                            r_pend_dist <= emit_dist;
                        end
                        case (r_step)
                            S_LIM: begin
                                r_llim   <= r_res;
                                r_side   <= 1'b0;
                                r_caps   <= '0;
                                r_pend_v <= 1'b0;
                                r_step   <= i_ray.cap_test ? S_CDIV : S_A1;
                            end
                            S_CDIV: begin
                                r_s    <= r_res;
                                r_step <= S_CPX;
                            end
                            S_CPX: begin
                                r_px   <= addw(i_ray.ox, r_res);
                                r_step <= S_CPZ;
                            end
                            S_CPZ: begin
                                r_pz   <= addw(i_ray.oz, r_res);
                                r_step <= S_CX2;
                            end
                            S_CX2: begin
                                r_t    <= r_res;
                                r_step <= S_CZ2;
                            end
                            S_CZ2: begin
                                if (r2_n <= ONE_Q && r_s >= eps_w && r_s <= r_llim) begin
                                    r_step <= S_CEMIT;
                                end else if (!r_side) begin
                                    r_side <= 1'b1;
                                    r_step <= S_CDIV;
                                end else begin
                                    r_step <= S_A1;
                                end
                            end
                            S_CEMIT: begin
                                r_caps <= r_caps + 1'b1;
                                if (!r_side) begin
                                    r_side <= 1'b1;
                                    r_step <= S_CDIV;
                                end else begin
                                    r_step <= (r_caps == 2'd1) ? S_DONE : S_A1;
                                end
                            end
                            S_A1: begin
                                r_t    <= r_res;
                                r_step <= S_A2;
                            end
                            S_A2: begin
                                r_a    <= r2_n;
                                r_step <= S_H1;
                            end
                            S_H1: begin
                                r_t    <= r_res;
                                r_step <= S_H2;
                            end
                            S_H2: begin
                                r_h    <= r2_n;
                                r_step <= S_C1;
                            end
                            S_C1: begin
                                r_t    <= r_res;
                                r_step <= S_C2;
                            end
                            S_C2: begin
                                r_c    <= addw(r2_n, -ONE_Q);
                                r_step <= S_E1;
                            end
                            S_E1: begin
                                r_t    <= r_res;
                                r_step <= S_E2;
                            end
                            S_E2: begin
                                r_e    <= e_n;
                                r_side <= 1'b0;
                                r_step <= (e4 > eps4 && r_a != '0) ? S_SQ : S_DONE;
                            end
                            S_SQ: begin
                                r_sq   <= r_res;
                                r_step <= S_SDIV;
                            end
                            S_SDIV: begin
                                r_s <= r_res;
                                if (r_res >= eps_w && r_res <= r_llim) begin
                                    r_step <= S_SPY;
                                end else if (!r_side) begin
                                    r_side <= 1'b1;
                                end else begin
                                    r_step <= S_DONE;
                                end
                            end
                            S_SPY: begin
                                if (py_n > -ONE_Q && py_n < ONE_Q) begin
                                    r_step <= S_SEMIT;
                                end else if (!r_side) begin
                                    r_side <= 1'b1;
                                    r_step <= S_SDIV;
                                end else begin
                                    r_step <= S_DONE;
                                end
                            end
                            S_SEMIT: begin
                                if (!r_side) begin
                                    r_side <= 1'b1;
                                    r_step <= S_SDIV;
                                end else begin
                                    r_step <= S_DONE;
                                end
                            end
                            S_DONE: begin
                                r_out_hit  <= r_pend_v;
                                r_out_surf <= r_pend_v ? r_pend_surf : SURF_BOTTOM;
                                r_out_dist <= r_pend_v ? r_pend_dist : '0;
                                r_out_last <= 1'b1;
                                r_pend_v   <= 1'b0;
                                r_phase    <= PH_IDLE;
                            end
                            default: begin
                                r_phase <= PH_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_done || ds_done) |-> (r_phase == PH_WAIT))
        else $error("arithmetic unit finished outside the wait phase");

    a_caps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_caps != 2'd3))
        else $error("more than two cap hits counted");

    a_miss_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_hit) |-> r_out_last)
        else $error("a miss beat is not the final beat of its ray");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_start && ds_start))
        else $error("two arithmetic units started together");

endmodule

>>> src/ray_capped_cylinder_intersect.sv
// Top level of the capped cylinder ray intersector.
// The back end runs each ray through the cap and side tests it reaches: the shared divide
// and square root unit produces one bit per cycle, with up to five divides per ray, and
// each product is formed on the four-partial-product multiplier. A two-beat ray queue lets
// new rays be accepted while the back end works, and an output register holds a finished
// beat until it is taken. A ray yields one to three result beats, the final one
// marked last.
module ray_capped_cylinder_intersect import rcc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [WORD_BITS-1:0] i_origin_x,
    input  logic [WORD_BITS-1:0] i_origin_y,
    input  logic [WORD_BITS-1:0] i_origin_z,
    input  logic [WORD_BITS-1:0] i_dir_x,
    input  logic [WORD_BITS-1:0] i_dir_y,
    input  logic [WORD_BITS-1:0] i_dir_z,
    input  logic [DISTW-1:0]     i_ray_limit,
    input  logic [DISTW-1:0]     i_scale_factor,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_hit_valid,
    output logic [1:0]           o_surface,
    output logic [DISTW-1:0]     o_distance,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [EPSW-1:0]      i_cfg_data
);

    logic q_valid;
    logic q_pop;
    t_ray q_head;

    rcc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_origin_z     (i_origin_z),
        .i_dir_x        (i_dir_x),
        .i_dir_y        (i_dir_y),
        .i_dir_z        (i_dir_z),
        .i_ray_limit    (i_ray_limit),
        .i_scale_factor (i_scale_factor),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_q_valid      (q_valid),
        .o_q_head       (q_head),
        .i_q_pop        (q_pop)
    );

    rcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_ray       (q_head),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hit_valid (o_hit_valid),
        .o_surface   (o_surface),
        .o_distance  (o_distance),
        .o_last      (o_last)
    );

endmodule

>>> verif/ray_checker.sv
// Watches the ray and hit channels, predicts the hit beats of each ray and compares them.
module ray_checker import rcc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_ready,
    input  logic [WORD_BITS-1:0] i_origin_x,
    input  logic [WORD_BITS-1:0] i_origin_y,
    input  logic [WORD_BITS-1:0] i_origin_z,
    input  logic [WORD_BITS-1:0] i_dir_x,
    input  logic [WORD_BITS-1:0] i_dir_y,
    input  logic [WORD_BITS-1:0] i_dir_z,
    input  logic [DISTW-1:0]     i_ray_limit,
    input  logic [DISTW-1:0]     i_scale_factor,
    input  logic                 o_valid,
    input  logic                 i_ready,
    input  logic                 o_hit_valid,
    input  logic [1:0]           o_surface,
    input  logic [DISTW-1:0]     o_distance,
    input  logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [EPSW-1:0]      i_cfg_data,
    output int                   o_pending,
    output int                   o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic             hit;
        logic [1:0]       surf;
        logic [DISTW-1:0] wdist;
        logic             last;
    } hit_beat_t;

    localparam longint W_MAX = (longint'(1) << MAGW) - 1;
    localparam longint ONE = longint'(1) << FRAC_BITS;
    localparam longint DMAX = (longint'(1) << DISTW) - 1;

    hit_beat_t hit_q[$];
    logic cyl_open;
    longint cyl_eps;

    assign o_pending = hit_q.size();

    function automatic longint sat(longint v);
        if (v > W_MAX) return W_MAX;
        if (v < -W_MAX) return -W_MAX;
        return v;
    endfunction

    function automatic longint unsigned absv(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        longint unsigned r;
        p = 128'(absv(a)) * 128'(absv(b));
        p = p >> FRAC_BITS;
        r = (p > 128'(W_MAX)) ? W_MAX : p[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint fx_div(longint n, longint d);
        longint unsigned un, ud, q;
        un = absv(n);
        ud = absv(d);
        q = un / ud;
        if (q > (W_MAX >> FRAC_BITS)) begin
            q = W_MAX;
        end else begin
            q = (un << FRAC_BITS) / ud;
            if (q > W_MAX) q = W_MAX;
        end
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint fx_sqrt(longint v);
        longint unsigned x, res, b;
        x = longint'(v) << FRAC_BITS;
        res = 0;
        b = longint'(1) << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic hit_beat_t make_hit(logic [1:0] surf, longint factor, longint s);
        hit_beat_t hb;
        longint w;
        w = fx_mul(factor, s);
        if (w < 0) w = 0;
        if (w > DMAX) w = DMAX;
        hb.hit = 1'b1;
        hb.surf = surf;
        hb.wdist = w[DISTW-1:0];
        hb.last = 1'b0;
        return hb;
    endfunction

    task automatic predict_ray();
        longint ox, oy, oz, dx, dy, dz, factor, llim, s, a, h, c, e, num, px, pz, r2, sq, py;
        longint unsigned fac;
        hit_beat_t beats[$];
        hit_beat_t nh;
        int caps;
        ox = longint'(signed'(i_origin_x));
        oy = longint'(signed'(i_origin_y));
        oz = longint'(signed'(i_origin_z));
        dx = longint'(signed'(i_dir_x));
        dy = longint'(signed'(i_dir_y));
        dz = longint'(signed'(i_dir_z));
        fac = i_scale_factor;
        caps = 0;
        if (fac == 0) fac = 1;
        factor = fac;
        if (i_ray_limit == DMAX[DISTW-1:0]) llim = W_MAX;
        else llim = fx_div(longint'(i_ray_limit), factor);

        if (!(absv(dy) < cyl_eps) && dy != 0 && !cyl_open) begin
            for (int sd = 0; sd < 2; sd++) begin
                num = (sd == 0) ? -(ONE + oy) : ONE - oy;
                s = fx_div(sat(num), dy);
                px = sat(ox + fx_mul(dx, s));
                pz = sat(oz + fx_mul(dz, s));
                r2 = sat(fx_mul(px, px) + fx_mul(pz, pz));
                if (r2 <= ONE && s >= cyl_eps && s <= llim) begin
                    beats.push_back(make_hit(sd == 0 ? SURF_BOTTOM : SURF_TOP, factor, s));
                    caps++;
                end
            end
        end

        if (caps < 2) begin
            a = sat(fx_mul(dx, dx) + fx_mul(dz, dz));
            h = sat(fx_mul(ox, dx) + fx_mul(oz, dz));
            c = sat(sat(fx_mul(ox, ox) + fx_mul(oz, oz)) - ONE);
            e = sat(fx_mul(h, h) - fx_mul(a, c));
            if (sat(4 * e) > cyl_eps && a != 0) begin
                sq = fx_sqrt(e);
                for (int sd = 0; sd < 2; sd++) begin
                    s = fx_div(sat(-h + (sd == 0 ? sq : -sq)), a);
                    if (s >= cyl_eps && s <= llim) begin
                        py = sat(oy + fx_mul(dy, s));
                        if (py > -ONE && py < ONE) beats.push_back(make_hit(SURF_SIDE, factor, s));
                    end
                end
            end
        end

        if (beats.size() == 0) begin
            nh.hit = 1'b0;
            nh.surf = SURF_BOTTOM;
            nh.wdist = '0;
            nh.last = 1'b0;
            beats.push_back(nh);
        end
        beats[beats.size()-1].last = 1'b1;
        foreach (beats[i]) hit_q.push_back(beats[i]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cyl_open <= 1'b0;
            cyl_eps <= longint'(EPS_RESET);
            hit_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_OPEN_ENDS) cyl_open <= i_cfg_data[0];
                else cyl_eps <= longint'(i_cfg_data);
            end
            if (i_valid && o_ready) predict_ray();
            if (o_valid && i_ready) begin
                if (hit_q.size() == 0) begin
                    $error("Hit beat with no beat expected");
                    o_errors <= o_errors + 1;
                end else begin
                    hit_beat_t ex;
                    ex = hit_q.pop_front();
                    if (ex.hit !== o_hit_valid || ex.surf !== o_surface ||
                        ex.wdist !== o_distance || ex.last !== o_last) begin
                        o_errors <= o_errors + 1;
                        if (ex.hit !== o_hit_valid)
                            $error("hit_valid: expected %0d, actual %0d", ex.hit, o_hit_valid);
                        if (ex.surf !== o_surface)
                            $error("surface: expected %0d, actual %0d", ex.surf, o_surface);
                        if (ex.wdist !== o_distance)
                            $error("distance: expected %0d, actual %0d", ex.wdist, o_distance);
                        if (ex.last !== o_last)
                            $error("last: expected %0d, actual %0d", ex.last, o_last);
                    end
                end
            end
        end
    end
endmodule

>>> verif/testbench.sv
// Top of the capped cylinder intersector testbench: clock, reset, ray stimulus and verdict.
module testbench;
    import rcc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNIT = 65536;

    logic                 i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    logic [WORD_BITS-1:0] i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z;
    logic [DISTW-1:0]     i_ray_limit, i_scale_factor, o_distance;
    logic                 o_hit_valid, o_last, i_cfg_we, i_cfg_index;
    logic [1:0]           o_surface;
    logic [EPSW-1:0]      i_cfg_data;
    int                   pending, errors, send_idle, recv_idle;

    ray_capped_cylinder_intersect i_dut (.*);

    ray_checker i_checker (.*, .o_pending(pending), .o_errors(errors));

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) i_ready <= ($urandom_range(99) >= recv_idle);

    function automatic logic [31:0] rnd_units(int r);
        return 32'($urandom_range(0, 2 * r * UNIT) - r * UNIT);
    endfunction

    task automatic send_ray(logic [31:0] ox, oy, oz, dx, dy, dz, logic [30:0] lim, fac);
        i_origin_x <= ox;
        i_origin_y <= oy;
        i_origin_z <= oz;
        i_dir_x <= dx;
        i_dir_y <= dy;
        i_dir_z <= dz;
        i_ray_limit <= lim;
        i_scale_factor <= fac;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        if ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic set_config(logic open, logic [EPSW-1:0] eps);
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (600) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_OPEN_ENDS;
        i_cfg_data <= EPSW'(open);
        @(posedge i_clk);
        i_cfg_index <= CFG_EPSILON;
        i_cfg_data <= eps;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_ray();
        logic [31:0] oy, dy;
        logic [30:0] lim, fac;
        int k;
        k = $urandom_range(99);
        lim = ($urandom_range(2) == 0) ? 31'h7fffffff : 31'($urandom_range(0, 40 * UNIT));
        fac = 31'($urandom_range(UNIT / 4, 4 * UNIT));
        if ($urandom_range(19) == 0) fac = 31'($urandom);
        if ($urandom_range(49) == 0) fac = '0;
        if (k < 70) begin
            oy = rnd_units(3);
            dy = rnd_units(2);
            if ($urandom_range(5) == 0) dy = 32'($urandom_range(0, 200) - 100);
            send_ray(rnd_units(3), oy, rnd_units(3), rnd_units(2), dy, rnd_units(2), lim, fac);
        end else if (k < 80) begin
            send_ray(rnd_units(1), rnd_units(1), rnd_units(1), rnd_units(1),
                     32'($urandom_range(0, 3 * UNIT) - UNIT), rnd_units(1), lim, fac);
        end else begin
            send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     31'($urandom), 31'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_OPEN_ENDS;
        i_cfg_data = '0;
        {i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z} = '0;
        i_ray_limit = '0;
        i_scale_factor = 31'(UNIT);
        send_idle = 8;
        recv_idle = 54;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_ray(0, -2 * UNIT, 0, 0, UNIT, 0, 31'h7fffffff, UNIT);
        send_ray(0, 2 * UNIT, UNIT / 4, 0, -UNIT, 0, 31'h7fffffff, 2 * UNIT);
        send_ray(-3 * UNIT, 0, 0, UNIT, 0, 0, 31'h7fffffff, UNIT);
        send_ray(0, 0, 0, UNIT, 0, 0, 31'h7fffffff, UNIT);
        send_ray(-3 * UNIT, 0, 0, UNIT, 0, 0, 3 * UNIT, UNIT);
        send_ray(-3 * UNIT, 0, 5 * UNIT, UNIT, 0, 0, 31'h7fffffff, UNIT);
        send_ray(-3 * UNIT, 0, 0, UNIT, 0, 0, 0, UNIT);
        send_ray(-3 * UNIT, 0, 0, UNIT, 0, 0, 31'h7fffffff, 0);
        send_ray(-3 * UNIT, 0, 0, UNIT, 0, 0, 31'h7fffffff, 31'h7fffffff);
        send_ray(-3 * UNIT, 0, 0, UNIT, 40, 0, 31'h7fffffff, UNIT);
        send_ray(0, -2 * UNIT, 0, UNIT / 2, UNIT, 0, 31'h7fffffff, UNIT);
        send_ray(0, 0, 0, 0, 0, 0, 31'h7fffffff, UNIT);
        send_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 31'h7fffffff, 31'h7fffffff);
        send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 31'h7ffffffe, 1);
        send_ray(UNIT, 0, 0, 0, 0, UNIT, 31'h7fffffff, UNIT);
        send_ray(0, -2 * UNIT, 0, 0, 32'hffffffff, 0, 31'h7fffffff, UNIT);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: set_config(1'b0, EPSW'($urandom_range(0, 2000)));
                2: set_config(1'b1, '0);
                3: set_config(1'b0, 16'hffff);
                4: set_config(1'b0, '0);
                default: ;
            endcase
            if (ph == 2) begin
                send_idle = 54;
                recv_idle = 8;
            end else if (ph == 4) begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (ph == 2) send_ray(0, -2 * UNIT, 0, 0, UNIT, 0, 31'h7fffffff, UNIT);
            repeat (82) random_ray();
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (700) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> sim.f
src/rcc_pkg.sv
src/rcc_front.sv
src/rcc_mul.sv
src/rcc_divsqrt.sv
src/rcc_back.sv
src/ray_capped_cylinder_intersect.sv
verif/ray_checker.sv
verif/testbench.sv
